@@ sv/chain_pivot_axis_rotation_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the chain pivot rotation block
// Clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef CHAIN_PIVOT_AXIS_ROTATION_ASSERT_SVH
`define CHAIN_PIVOT_AXIS_ROTATION_ASSERT_SVH

// same-cycle implication
`define CPAR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPAR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cpar_pkg.sv @@
// ----------------------------------------------------------------------------
// cpar_pkg
// Types, codes, constants and helper functions of the pivot rotation block.
// ----------------------------------------------------------------------------
package cpar_pkg;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        angle;
        logic               last_bead;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic               axis_degenerate;
        logic               last_out;
    } out_item_t;

    typedef struct packed {
        logic [3:0] op;
        logic [5:0] idx;
        logic [1:0] sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic m_zero;
        logic norm_done;
        logic degen;
        logic out_free;
    } sts_t;

    localparam logic [1:0] OP_TAIL  = 2'd0;
    localparam logic [1:0] OP_PIVOT = 2'd1;
    localparam logic [1:0] OP_ROT   = 2'd2;

    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_TAIL  = 4'd1;
    localparam logic [3:0] CMD_PIVOT = 4'd2;
    localparam logic [3:0] CMD_BEAD  = 4'd3;
    localparam logic [3:0] CMD_DIFF  = 4'd4;
    localparam logic [3:0] CMD_MAX   = 4'd5;
    localparam logic [3:0] CMD_DEGEN = 4'd6;
    localparam logic [3:0] CMD_NORM  = 4'd7;
    localparam logic [3:0] CMD_SQ    = 4'd8;
    localparam logic [3:0] CMD_SQRT  = 4'd9;
    localparam logic [3:0] CMD_DIV   = 4'd10;
    localparam logic [3:0] CMD_COR   = 4'd11;
    localparam logic [3:0] CMD_MUL   = 4'd12;
    localparam logic [3:0] CMD_BUILD = 4'd13;
    localparam logic [3:0] CMD_ROT   = 4'd14;
    localparam logic [3:0] CMD_PASS  = 4'd15;

    localparam logic [5:0] SQ_LAST   = 6'd3;
    localparam logic [5:0] SQRT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd62;
    localparam logic [5:0] COR_LAST  = 6'd31;
    localparam logic [5:0] MUL_LAST  = 6'd29;
    localparam logic [5:0] ROT_LAST  = 6'd9;

    localparam logic signed [31:0] Q_ONE     = 32'sd1073741824;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat_unit(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd1073741824)
            r = Q_ONE;
        else if (v < -37'sd1073741824)
            r = -Q_ONE;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_coord(input logic signed [38:0] v);
        logic signed [31:0] r;
        if (v > 39'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -39'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ sv/cpar_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpar_ctrl
// Sequencer: steps the datapath through setup, rotation and output hand-off.
// ----------------------------------------------------------------------------
module cpar_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    req_op,
    output logic          req_ready,
    input  cpar_pkg::sts_t sts,
    output cpar_pkg::cmd_t cmd
);
    import cpar_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MAX   = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_COR   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_BUILD = 4'd9;
    localparam logic [3:0] S_ROT   = 4'd10;
    localparam logic [3:0] S_PASS  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 6'd0;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        cmd.op       = CMD_NONE;
        cmd.idx      = cnt_reg;
        cmd.sel      = sel_reg;
        cmd.out_load = 1'b0;
        req_ready    = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_op)
                        OP_TAIL:  cmd.op = CMD_TAIL;
                        OP_PIVOT:
                        begin
                            cmd.op     = CMD_PIVOT;
                            state_next = S_DIFF;
                        end
                        OP_ROT:
                        begin
                            cmd.op     = CMD_BEAD;
                            cnt_next   = 6'd0;
                            state_next = sts.degen ? S_PASS : S_ROT;
                        end
                        default: cmd.op = CMD_NONE;
                    endcase
                end
            end
            S_DIFF:
            begin
                cmd.op     = CMD_DIFF;
                state_next = S_MAX;
            end
            S_MAX:
            begin
                cmd.op     = CMD_MAX;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                priority if (sts.m_zero)
                begin
                    cmd.op     = CMD_DEGEN;
                    state_next = S_IDLE;
                end
                else if (sts.norm_done)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_SQ;
                end
                else
                    cmd.op = CMD_NORM;
            end
            S_SQ:
            begin
                cmd.op = CMD_SQ;
                if (cnt_reg == SQ_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_SQRT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_SQRT:
            begin
                cmd.op = CMD_SQRT;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next   = 6'd0;
                    sel_next   = 2'd0;
                    state_next = S_DIV;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_DIV:
            begin
                cmd.op = CMD_DIV;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = 6'd0;
                    if (sel_reg == 2'd2)
                        state_next = S_COR;
                    else
                        sel_next = sel_reg + 2'd1;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_COR:
            begin
                cmd.op = CMD_COR;
                if (cnt_reg == COR_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_MUL;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_MUL:
            begin
                cmd.op = CMD_MUL;
                if (cnt_reg == MUL_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_BUILD;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_BUILD:
            begin
                cmd.op     = CMD_BUILD;
                state_next = S_IDLE;
            end
            S_ROT:
            begin
                cmd.op = CMD_ROT;
                if (cnt_reg == ROT_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = S_OUT;
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            S_PASS:
            begin
                cmd.op     = CMD_PASS;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/cpar_datapath.sv @@
// ----------------------------------------------------------------------------
// cpar_datapath
// Stored points, shared multiplier, root, divider, CORDIC, matrix and output.
// ----------------------------------------------------------------------------
module cpar_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  cpar_pkg::cmd_t     cmd,
    input  cpar_pkg::in_item_t req,
    output cpar_pkg::sts_t     sts,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output cpar_pkg::out_item_t rsp
);
    import cpar_pkg::*;

    logic signed [31:0] tail_reg  [3];
    logic signed [31:0] pivot_reg [3];
    logic signed [31:0] mat_reg   [9];
    logic               degen_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [15:0]        angle_reg;
    logic signed [33:0] d_reg [3];
    logic [33:0]        m_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [60:0]        div_num_reg;
    logic [31:0]        div_rem_reg;
    logic [30:0]        div_q_reg;
    logic signed [31:0] u_reg [3];
    logic signed [33:0] cx_reg, cy_reg, cz_reg, c_reg, s_reg;
    logic signed [67:0] prod_reg, acc_reg;
    logic signed [35:0] qxx_reg, qyy_reg, qzz_reg, qxy_reg, qxz_reg, qyz_reg;
    logic signed [35:0] sx_reg, sy_reg, sz_reg;
    logic signed [31:0] b_reg [3];
    logic signed [32:0] r_reg [3];
    logic signed [31:0] res_reg [3];
    logic               last_reg;

    logic [33:0]        mag [3];
    logic [33:0]        max_mag;
    logic signed [33:0] mul_a, mul_b;
    logic [1:0]         sq_i;
    logic [3:0]         mstep;
    logic [3:0]         rot_i;
    logic [1:0]         rot_col;
    logic signed [33:0] omc;
    logic signed [31:0] entry [9];
    logic [63:0]        sq_t;
    logic [32:0]        rem_sh, rem_sub;
    logic [4:0]         cor_i;
    logic signed [33:0] cx_sh, cy_sh;
    logic signed [67:0] acc_sum;
    logic [1:0]         rot_row;
    logic               rot_end;
    logic signed [31:0] rot_val;
    logic signed [35:0] mul_wb;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            mag[j] = d_reg[j][33] ? 34'(-d_reg[j]) : 34'(d_reg[j]);
        max_mag = mag[0];
        if (mag[1] > max_mag)
            max_mag = mag[1];
        if (mag[2] > max_mag)
            max_mag = mag[2];
    end

    assign sts.m_zero    = (m_reg == 34'd0);
    assign sts.norm_done = (m_reg < 34'd1073741824) && (m_reg >= 34'd536870912);
    assign sts.degen     = degen_reg;
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    assign omc     = 34'sd1073741824 - c_reg;
    assign sq_i    = (cmd.idx[1:0] == 2'd3) ? 2'd0 : cmd.idx[1:0];
    assign mstep   = cmd.idx[4:1];
    assign rot_i   = (cmd.idx < 6'd9) ? cmd.idx[3:0] : 4'd0;
    assign cor_i   = 5'(cmd.idx - 6'd1);
    assign cx_sh   = cx_reg >>> cor_i;
    assign cy_sh   = cy_reg >>> cor_i;
    assign sq_t    = sq_res_reg + sq_bit_reg;
    assign rem_sh  = {div_rem_reg, div_num_reg[60]};
    assign rem_sub = rem_sh - {1'b0, sq_res_reg[31:0]};
    assign acc_sum = acc_reg + prod_reg;
    assign mul_wb  = 36'(prod_reg >>> 30);

    always_comb
    begin
        unique case (rot_i)
            4'd0, 4'd3, 4'd6: rot_col = 2'd0;
            4'd1, 4'd4, 4'd7: rot_col = 2'd1;
            default:          rot_col = 2'd2;
        endcase
        rot_end = 1'b0;
        rot_row = 2'd0;
        unique case (cmd.idx)
            6'd3:
            begin
                rot_end = 1'b1;
                rot_row = 2'd0;
            end
            6'd6:
            begin
                rot_end = 1'b1;
                rot_row = 2'd1;
            end
            6'd9:
            begin
                rot_end = 1'b1;
                rot_row = 2'd2;
            end
            default: rot_end = 1'b0;
        endcase
        rot_val = sat_coord(39'(pivot_reg[rot_row]) + 39'($signed(acc_sum[67:30])));
    end

    always_comb
    begin
        mul_a = 34'sd0;
        mul_b = 34'sd0;
        unique case (cmd.op)
            CMD_SQ:
            begin
                mul_a = d_reg[sq_i];
                mul_b = d_reg[sq_i];
            end
            CMD_MUL:
            begin
                unique case (mstep)
                    4'd0:  begin mul_a = 34'(u_reg[0]); mul_b = 34'(u_reg[0]); end
                    4'd1:  begin mul_a = 34'(u_reg[1]); mul_b = 34'(u_reg[1]); end
                    4'd2:  begin mul_a = 34'(u_reg[2]); mul_b = 34'(u_reg[2]); end
                    4'd3:  begin mul_a = 34'(u_reg[0]); mul_b = 34'(u_reg[1]); end
                    4'd4:  begin mul_a = 34'(u_reg[0]); mul_b = 34'(u_reg[2]); end
                    4'd5:  begin mul_a = 34'(u_reg[1]); mul_b = 34'(u_reg[2]); end
                    4'd6:  begin mul_a = $signed(qxx_reg[33:0]); mul_b = omc; end
                    4'd7:  begin mul_a = $signed(qyy_reg[33:0]); mul_b = omc; end
                    4'd8:  begin mul_a = $signed(qzz_reg[33:0]); mul_b = omc; end
                    4'd9:  begin mul_a = $signed(qxy_reg[33:0]); mul_b = omc; end
                    4'd10: begin mul_a = $signed(qxz_reg[33:0]); mul_b = omc; end
                    4'd11: begin mul_a = $signed(qyz_reg[33:0]); mul_b = omc; end
                    4'd12: begin mul_a = 34'(u_reg[0]); mul_b = s_reg; end
                    4'd13: begin mul_a = 34'(u_reg[1]); mul_b = s_reg; end
                    4'd14: begin mul_a = 34'(u_reg[2]); mul_b = s_reg; end
                    default: mul_a = 34'sd0;
                endcase
            end
            CMD_ROT:
            begin
                mul_a = 34'(mat_reg[rot_i]);
                mul_b = 34'(r_reg[rot_col]);
            end
            default: mul_a = 34'sd0;
        endcase
    end

    always_comb
    begin
        entry[0] = sat_unit(37'(c_reg) + 37'(qxx_reg));
        entry[1] = sat_unit(37'(qxy_reg) - 37'(sz_reg));
        entry[2] = sat_unit(37'(qxz_reg) + 37'(sy_reg));
        entry[3] = sat_unit(37'(qxy_reg) + 37'(sz_reg));
        entry[4] = sat_unit(37'(c_reg) + 37'(qyy_reg));
        entry[5] = sat_unit(37'(qyz_reg) - 37'(sx_reg));
        entry[6] = sat_unit(37'(qxz_reg) - 37'(sy_reg));
        entry[7] = sat_unit(37'(qyz_reg) + 37'(sx_reg));
        entry[8] = sat_unit(37'(c_reg) + 37'(qzz_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 3; j++)
            begin
                tail_reg[j]  <= 32'sd0;
                pivot_reg[j] <= 32'sd0;
            end
            for (int j = 0; j < 9; j++)
                mat_reg[j] <= (j % 4 == 0) ? Q_ONE : 32'sd0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                CMD_TAIL:
                begin
                    tail_reg[0] <= req.coord_x;
                    tail_reg[1] <= req.coord_y;
                    tail_reg[2] <= req.coord_z;
                end
                CMD_PIVOT:
                begin
                    pivot_reg[0] <= req.coord_x;
                    pivot_reg[1] <= req.coord_y;
                    pivot_reg[2] <= req.coord_z;
                end
                CMD_DEGEN:
                begin
                    degen_reg <= 1'b1;
                    for (int j = 0; j < 9; j++)
                        mat_reg[j] <= (j % 4 == 0) ? Q_ONE : 32'sd0;
                end
                CMD_BUILD:
                begin
                    degen_reg <= 1'b0;
                    for (int j = 0; j < 9; j++)
                        mat_reg[j] <= entry[j];
                end
                default: degen_reg <= degen_reg;
            endcase
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_SQ || cmd.op == CMD_ROT || (cmd.op == CMD_MUL && !cmd.idx[0]))
            prod_reg <= mul_a * mul_b;
        if (cmd.out_load)
        begin
            out_reg.rot_x           <= res_reg[0];
            out_reg.rot_y           <= res_reg[1];
            out_reg.rot_z           <= res_reg[2];
            out_reg.axis_degenerate <= degen_reg;
            out_reg.last_out        <= last_reg;
        end
        unique case (cmd.op)
            CMD_PIVOT: angle_reg <= req.angle;
            CMD_BEAD:
            begin
                b_reg[0] <= req.coord_x;
                b_reg[1] <= req.coord_y;
                b_reg[2] <= req.coord_z;
                r_reg[0] <= 33'(req.coord_x) - 33'(pivot_reg[0]);
                r_reg[1] <= 33'(req.coord_y) - 33'(pivot_reg[1]);
                r_reg[2] <= 33'(req.coord_z) - 33'(pivot_reg[2]);
                last_reg <= req.last_bead;
                acc_reg  <= 68'sd0;
            end
            CMD_DIFF:
            begin
                for (int j = 0; j < 3; j++)
                    d_reg[j] <= 34'(pivot_reg[j]) - 34'(tail_reg[j]);
            end
            CMD_MAX: m_reg <= max_mag;
            CMD_NORM:
            begin
                if (m_reg >= 34'd1073741824)
                begin
                    m_reg <= m_reg >> 1;
                    for (int j = 0; j < 3; j++)
                        d_reg[j] <= d_reg[j] >>> 1;
                end
                else
                begin
                    m_reg <= m_reg << 1;
                    for (int j = 0; j < 3; j++)
                        d_reg[j] <= d_reg[j] <<< 1;
                end
            end
            CMD_SQ:
            begin
                if (cmd.idx == 6'd1)
                    sum_reg <= prod_reg[63:0];
                else if (cmd.idx != 6'd0)
                    sum_reg <= sum_reg + prod_reg[63:0];
            end
            CMD_SQRT:
            begin
                if (cmd.idx == 6'd0)
                begin
                    sq_n_reg   <= sum_reg;
                    sq_res_reg <= 64'd0;
                    sq_bit_reg <= 64'd1 << 62;
                end
                else
                begin
                    if (sq_n_reg >= sq_t)
                    begin
                        sq_n_reg   <= sq_n_reg - sq_t;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
            end
            CMD_DIV:
            begin
                priority if (cmd.idx == 6'd0)
                begin
                    div_num_reg <= {mag[cmd.sel][30:0], 30'd0};
                    div_rem_reg <= 32'd0;
                    div_q_reg   <= 31'd0;
                end
                else if (cmd.idx == DIV_LAST)
                begin
                    u_reg[cmd.sel] <= d_reg[cmd.sel][33] ? -$signed({1'b0, div_q_reg})
                                                         : $signed({1'b0, div_q_reg});
                end
                else
                begin
                    div_num_reg <= div_num_reg << 1;
                    if (!rem_sub[32])
                    begin
                        div_rem_reg <= rem_sub[31:0];
                        div_q_reg   <= {div_q_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        div_rem_reg <= rem_sh[31:0];
                        div_q_reg   <= {div_q_reg[29:0], 1'b0};
                    end
                end
            end
            CMD_COR:
            begin
                priority if (cmd.idx == 6'd0)
                begin
                    cx_reg <= CORDIC_X0;
                    cy_reg <= 34'sd0;
                    cz_reg <= $signed({4'd0, angle_reg[13:0], 16'd0});
                end
                else if (cmd.idx == COR_LAST)
                begin
                    unique case (angle_reg[15:14])
                        2'd0:
                        begin
                            c_reg <= cx_reg;
                            s_reg <= cy_reg;
                        end
                        2'd1:
                        begin
                            c_reg <= -cy_reg;
                            s_reg <= cx_reg;
                        end
                        2'd2:
                        begin
                            c_reg <= -cx_reg;
                            s_reg <= -cy_reg;
                        end
                        default:
                        begin
                            c_reg <= cy_reg;
                            s_reg <= -cx_reg;
                        end
                    endcase
                end
                else if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_turn(cor_i);
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_turn(cor_i);
                end
            end
            CMD_MUL:
            begin
                if (cmd.idx[0])
                begin
                    unique case (mstep)
                        4'd0, 4'd6:  qxx_reg <= mul_wb;
                        4'd1, 4'd7:  qyy_reg <= mul_wb;
                        4'd2, 4'd8:  qzz_reg <= mul_wb;
                        4'd3, 4'd9:  qxy_reg <= mul_wb;
                        4'd4, 4'd10: qxz_reg <= mul_wb;
                        4'd5, 4'd11: qyz_reg <= mul_wb;
                        4'd12:       sx_reg  <= mul_wb;
                        4'd13:       sy_reg  <= mul_wb;
                        default:     sz_reg  <= mul_wb;
                    endcase
                end
            end
            CMD_ROT:
            begin
                if (cmd.idx != 6'd0)
                begin
                    if (rot_end)
                    begin
                        res_reg[rot_row] <= rot_val;
                        acc_reg          <= 68'sd0;
                    end
                    else
                        acc_reg <= acc_sum;
                end
            end
            CMD_PASS:
            begin
                for (int j = 0; j < 3; j++)
                    res_reg[j] <= b_reg[j];
            end
            default: last_reg <= last_reg;
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

@@ sv/chain_pivot_axis_rotation.sv @@
// ----------------------------------------------------------------------------
// chain_pivot_axis_rotation
// Pivot move of a 3-D bead chain: rotate later beads about the tail-pivot axis.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req): op 0 stores the tail bead in the
// accept cycle; op 1 stores the pivot and angle, then builds the rotation
// matrix; op 2 rotates one bead; op 3 is dropped. Ops 0, 1 and 3 give no
// response. Response channel (rsp_valid/rsp_ready/rsp) carries one rotated
// bead per op 2 request, with the degenerate-axis flag and last marker.
// A bead passes from accept through the shared 34x34 multiplier and
// accumulator, then waits for the output slot and loads the output register;
// a zero-length axis bypasses the multiplier. One bead is in flight at a
// time, so a new bead is taken only after the last one is loaded into the
// output register.
// Matrix setup after op 1 includes the shift normalize loop, the 32-step
// square root, three 61-step dividers and the 30-step CORDIC; a zero-length
// axis ends it at the normalize step.
// req_ready is low throughout.
// Reset clears tail and pivot to zero, the matrix to identity and the
// degenerate flag. A stalled receiver holds the response in the output
// register; the next request is still accepted and a second bead waits
// for the slot to free.
// ----------------------------------------------------------------------------
module chain_pivot_axis_rotation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  cpar_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cpar_pkg::out_item_t rsp
);
    import cpar_pkg::*;

    `include "chain_pivot_axis_rotation_assert.svh"

    cmd_t cmd;
    sts_t sts;

    cpar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpar_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `CPAR_CHECK(a_load_into_free_slot, cmd.out_load, sts.out_free, "output overwritten")
    `CPAR_CHECK_NEXT(a_busy_after_bead, req_valid && req_ready && req.op == OP_ROT, !req_ready, "bead not held busy")
    `CPAR_CHECK_NEXT(a_drain_clears, rsp_valid && rsp_ready && !cmd.out_load, !rsp_valid, "response repeated")

endmodule
